// File: rtl/landing_window_gate_hysteresis_assert.svh
// Assertion macros shared by the landing window gate RTL.
`ifndef LANDING_WINDOW_GATE_HYSTERESIS_ASSERT_SVH
`define LANDING_WINDOW_GATE_HYSTERESIS_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define LWGH_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("landing window gate check failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define LWGH_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("landing window gate check failed");

`endif

// File: rtl/lwgh_pkg.sv
// Shared constants, types and the cosine table of the landing window gate.
package lwgh_pkg;

	localparam int COS_TABLE_DEPTH = 1024;
	localparam int COS_QTR_LAST = COS_TABLE_DEPTH / 2;
	localparam int COS_IDX_W = $clog2(COS_TABLE_DEPTH + 1);
	localparam int COS_QIDX_W = $clog2(COS_QTR_LAST + 1);
	localparam int COS_PROD_W = 16 + COS_IDX_W;
	localparam longint unsigned PI_Q30 = 64'd3373259426;

	localparam logic [31:0] RST_HORIZ_ERR_LIMITS = 32'd26214600;
	localparam logic [31:0] RST_SPEED_LIMITS = 32'd32768300;
	localparam logic [31:0] RST_TILT_COS_LIMITS = 32'd1052393390;
	localparam logic [15:0] RST_MAX_VISUAL_AGE = 16'd200;
	localparam logic [14:0] RST_MIN_HEIGHT = 15'd0;
	localparam logic [14:0] RST_MAX_HEIGHT = 15'd5000;
	localparam logic [31:0] RST_REQUIRED_DURATION = 32'd1000;

	typedef enum logic [2:0] {
		REG_HORIZ_ERR_LIMITS = 3'd0,
		REG_SPEED_LIMITS = 3'd1,
		REG_TILT_COS_LIMITS = 3'd2,
		REG_MAX_VISUAL_AGE = 3'd3,
		REG_MIN_HEIGHT = 3'd4,
		REG_MAX_HEIGHT = 3'd5,
		REG_REQUIRED_DURATION = 3'd6
	} cfg_reg_t;

	// Bit positions of the reject mask
	localparam int REJ_TIME = 0;
	localparam int REJ_VISUAL_ABSENT = 1;
	localparam int REJ_VISUAL_OLD = 2;
	localparam int REJ_ESTIMATE = 3;
	localparam int REJ_PREDICTION = 4;
	localparam int REJ_ERROR = 5;
	localparam int REJ_SPEED = 6;
	localparam int REJ_TILT = 7;
	localparam int REJ_HEIGHT = 8;
	localparam int REJ_W = 9;

	// Checks that do not depend on the window state
	typedef struct packed {
		logic vis_absent;
		logic vis_old;
		logic est_bad;
		logic pred_bad;
		logic err_over_enter;
		logic err_over_exit;
		logic spd_over_enter;
		logic spd_over_exit;
		logic height_bad;
	} chk_t;

	typedef logic signed [15:0] cos_quarter_t [0:COS_QTR_LAST];

	// Floor quotient by shift and subtract; used only while building the table
	function automatic longint unsigned div_floor(longint unsigned num, longint unsigned den);
		longint unsigned rem;
		longint unsigned quo;
		rem = 64'd0;
		quo = 64'd0;
		for (int b = 63; b >= 0; b--) begin
			rem = (rem << 1) | ((num >> b) & 64'd1);
			quo = quo << 1;
			if (rem >= den) begin
				rem = rem - den;
				quo = quo | 64'd1;
			end
		end
		return quo;
	endfunction

	// Taylor series of cos(pi*j/DEPTH) in Q30, rounded to Q1.14
	function automatic logic signed [15:0] quarter_cos(int unsigned j);
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint sum;
		longint r;
		x = (PI_Q30 * longint'(j)) / COS_TABLE_DEPTH;
		x2 = (x * x) >> 30;
		term = 64'd1 << 30;
		sum = longint'(term);
		for (int n = 1; n <= 12; n++) begin
			term = div_floor((term * x2) >> 30, longint'((2 * n - 1) * (2 * n)));
			if ((n & 1) == 1) begin
				sum = sum - longint'(term);
			end else begin
				sum = sum + longint'(term);
			end
		end
		if (sum < 0) begin
			sum = 0;
		end
		r = (sum + (64'sd1 <<< 15)) >>> 16;
		if (r > 16384) begin
			r = 16384;
		end
		return 16'(r);
	endfunction

	function automatic cos_quarter_t build_cos_quarter();
		cos_quarter_t t;
		for (int j = 0; j <= COS_QTR_LAST; j++) begin
			t[j] = quarter_cos(j);
		end
		return t;
	endfunction

	localparam cos_quarter_t COS_QUARTER = build_cos_quarter();

endpackage

// File: rtl/landing_window_gate_hysteresis.sv
// Landing window gate: per-sample checks with enter/exit hysteresis and a dwell timer.
// Throughput: one item per cycle while out_stall is low; four registered stages, the window state in the last.
// Reset (arst_n low): window closed, dwell and time history cleared, registers to defaults.
// Stages: input register, cosine table read, cos product, checks and state update.
`include "landing_window_gate_hysteresis_assert.svh"

module landing_window_gate_hysteresis (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [31:0]        now_ms,
	input  logic               marker_seen,
	input  logic [15:0]        visual_age_ms,
	input  logic               pose_ok,
	input  logic               motion_pred_ok,
	input  logic [15:0]        horiz_error_mm,
	input  logic [15:0]        rel_speed_mm_s,
	input  logic signed [15:0] deck_roll,
	input  logic signed [15:0] deck_pitch,
	input  logic signed [15:0] rel_height_mm,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               gate_open,
	output logic               conditions_met,
	output logic [31:0]        held_ms,
	output logic [8:0]         reject_mask
);

	// configuration
	logic [31:0] horiz_error_limits_q;
	logic [31:0] speed_limits_q;
	logic [31:0] tilt_cos_limits_q;
	logic [15:0] max_visual_age_q;
	logic [14:0] min_height_q;
	logic [14:0] max_height_q;
	logic [31:0] required_duration_q;

	// gate state
	logic        open_q;
	logic        held_valid_q;
	logic [31:0] held_start_q;
	logic        last_time_valid_q;
	logic [31:0] last_time_q;

	// pipeline
	logic vld_s1, vld_s2, vld_s3;
	logic ready1, ready2, ready3, ready_o, mv3;
	logic [31:0] now_s1, now_s2, now_s3;
	logic marker_seen_s1, pose_ok_s1, motion_pred_ok_s1;
	logic [15:0] visual_age_s1, horiz_error_s1, rel_speed_s1;
	logic signed [15:0] deck_roll_s1, deck_pitch_s1, rel_height_s1;
	lwgh_pkg::chk_t chk_d, chk_s2, chk_s3;
	logic signed [15:0] cos_roll_s2, cos_pitch_s2;
	logic signed [31:0] tilt_prod_s3;

	// output register
	logic out_valid_q;
	logic gate_open_q, conditions_met_q;
	logic [31:0] held_q;
	logic [lwgh_pkg::REJ_W-1:0] reject_q;

	// final stage
	logic time_back;
	logic signed [15:0] cos_lim;
	logic signed [31:0] cos_lim_scaled;
	logic [lwgh_pkg::REJ_W-1:0] mask;
	logic [31:0] start_n, held_n;
	logic open_n;

	assign ready_o = !out_valid_q || !out_stall;
	assign ready3 = !vld_s3 || ready_o;
	assign ready2 = !vld_s2 || ready3;
	assign ready1 = !vld_s1 || ready2;
	assign mv3 = vld_s3 && ready_o;
	assign in_stall = !ready1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			horiz_error_limits_q <= lwgh_pkg::RST_HORIZ_ERR_LIMITS;
			speed_limits_q <= lwgh_pkg::RST_SPEED_LIMITS;
			tilt_cos_limits_q <= lwgh_pkg::RST_TILT_COS_LIMITS;
			max_visual_age_q <= lwgh_pkg::RST_MAX_VISUAL_AGE;
			min_height_q <= lwgh_pkg::RST_MIN_HEIGHT;
			max_height_q <= lwgh_pkg::RST_MAX_HEIGHT;
			required_duration_q <= lwgh_pkg::RST_REQUIRED_DURATION;
		end else if (cfg_we) begin
			unique case (lwgh_pkg::cfg_reg_t'(cfg_index))
				lwgh_pkg::REG_HORIZ_ERR_LIMITS: horiz_error_limits_q <= cfg_data;
				lwgh_pkg::REG_SPEED_LIMITS: speed_limits_q <= cfg_data;
				lwgh_pkg::REG_TILT_COS_LIMITS: tilt_cos_limits_q <= cfg_data;
				lwgh_pkg::REG_MAX_VISUAL_AGE: max_visual_age_q <= cfg_data[15:0];
				lwgh_pkg::REG_MIN_HEIGHT: min_height_q <= cfg_data[14:0];
				lwgh_pkg::REG_MAX_HEIGHT: max_height_q <= cfg_data[14:0];
				lwgh_pkg::REG_REQUIRED_DURATION: required_duration_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// stage 1: input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (ready1) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && ready1) begin
			now_s1 <= now_ms;
			marker_seen_s1 <= marker_seen;
			visual_age_s1 <= visual_age_ms;
			pose_ok_s1 <= pose_ok;
			motion_pred_ok_s1 <= motion_pred_ok;
			horiz_error_s1 <= horiz_error_mm;
			rel_speed_s1 <= rel_speed_mm_s;
			deck_roll_s1 <= deck_roll;
			deck_pitch_s1 <= deck_pitch;
			rel_height_s1 <= rel_height_mm;
		end
	end

	// stage 2: state-free checks and cosine lookups
	always_comb begin
		chk_d.vis_absent = !marker_seen_s1;
		chk_d.vis_old = visual_age_s1 > max_visual_age_q;
		chk_d.est_bad = !pose_ok_s1;
		chk_d.pred_bad = !motion_pred_ok_s1;
		chk_d.err_over_enter = horiz_error_s1 > horiz_error_limits_q[15:0];
		chk_d.err_over_exit = horiz_error_s1 > horiz_error_limits_q[31:16];
		chk_d.spd_over_enter = rel_speed_s1 > speed_limits_q[15:0];
		chk_d.spd_over_exit = rel_speed_s1 > speed_limits_q[31:16];
		chk_d.height_bad = (rel_height_s1 < $signed({1'b0, min_height_q}))
			|| (rel_height_s1 > $signed({1'b0, max_height_q}));
	end

	lwgh_cos_rom u_cos_roll (
		.clk   (clk),
		.en    (ready2 && vld_s1),
		.angle (deck_roll_s1),
		.cos_q (cos_roll_s2)
	);

	lwgh_cos_rom u_cos_pitch (
		.clk   (clk),
		.en    (ready2 && vld_s1),
		.angle (deck_pitch_s1),
		.cos_q (cos_pitch_s2)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (ready2) begin
				vld_s2 <= vld_s1;
			end
			if (ready3) begin
				vld_s3 <= vld_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ready2 && vld_s1) begin
			now_s2 <= now_s1;
			chk_s2 <= chk_d;
		end
		// stage 3: tilt product
		if (ready3 && vld_s2) begin
			now_s3 <= now_s2;
			chk_s3 <= chk_s2;
			tilt_prod_s3 <= cos_roll_s2 * cos_pitch_s2;
		end
	end

	// stage 4: limits by window state, dwell timer
	always_comb begin
		time_back = last_time_valid_q && (now_s3 < last_time_q);
		cos_lim = open_q ? $signed(tilt_cos_limits_q[31:16]) : $signed(tilt_cos_limits_q[15:0]);
		cos_lim_scaled = $signed({{2{cos_lim[15]}}, cos_lim, 14'b0});
		mask = '0;
		mask[lwgh_pkg::REJ_VISUAL_ABSENT] = chk_s3.vis_absent;
		mask[lwgh_pkg::REJ_VISUAL_OLD] = chk_s3.vis_old;
		mask[lwgh_pkg::REJ_ESTIMATE] = chk_s3.est_bad;
		mask[lwgh_pkg::REJ_PREDICTION] = chk_s3.pred_bad;
		mask[lwgh_pkg::REJ_ERROR] = open_q ? chk_s3.err_over_exit : chk_s3.err_over_enter;
		mask[lwgh_pkg::REJ_SPEED] = open_q ? chk_s3.spd_over_exit : chk_s3.spd_over_enter;
		mask[lwgh_pkg::REJ_TILT] = tilt_prod_s3 < cos_lim_scaled;
		mask[lwgh_pkg::REJ_HEIGHT] = chk_s3.height_bad;
		start_n = held_valid_q ? held_start_q : now_s3;
		held_n = now_s3 - start_n;
		open_n = open_q || (held_n >= required_duration_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= 1'b0;
			held_valid_q <= 1'b0;
			held_start_q <= '0;
			last_time_valid_q <= 1'b0;
			last_time_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ready_o) begin
				out_valid_q <= vld_s3;
			end
			if (mv3) begin
				priority if (time_back) begin
					// time ran backwards: drop all history
					open_q <= 1'b0;
					held_valid_q <= 1'b0;
					held_start_q <= '0;
					last_time_valid_q <= 1'b0;
					last_time_q <= '0;
				end else if (mask != '0) begin
					last_time_valid_q <= 1'b1;
					last_time_q <= now_s3;
					open_q <= 1'b0;
					held_valid_q <= 1'b0;
					held_start_q <= '0;
				end else begin
					last_time_valid_q <= 1'b1;
					last_time_q <= now_s3;
					open_q <= open_n;
					held_valid_q <= 1'b1;
					held_start_q <= start_n;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mv3) begin
			priority if (time_back) begin
				gate_open_q <= 1'b0;
				conditions_met_q <= 1'b0;
				held_q <= '0;
				reject_q <= lwgh_pkg::REJ_W'(1) << lwgh_pkg::REJ_TIME;
			end else if (mask != '0) begin
				gate_open_q <= 1'b0;
				conditions_met_q <= 1'b0;
				held_q <= '0;
				reject_q <= mask;
			end else begin
				gate_open_q <= open_n;
				conditions_met_q <= 1'b1;
				held_q <= held_n;
				reject_q <= '0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign gate_open = gate_open_q;
	assign conditions_met = conditions_met_q;
	assign held_ms = held_q;
	assign reject_mask = reject_q;

	`LWGH_ASSERT_NOW(a_open_needs_clean, out_valid_q && gate_open_q, conditions_met_q)
	`LWGH_ASSERT_NOW(a_reject_zero_held, out_valid_q && (reject_q != '0), held_q == '0)
	`LWGH_ASSERT_NOW(a_closed_below_dwell,
		out_valid_q && conditions_met_q && !gate_open_q, held_q < required_duration_q)
	`LWGH_ASSERT_NOW(a_open_has_dwell, open_q, held_valid_q && last_time_valid_q)
	`LWGH_ASSERT_NEXT(a_time_back_clears, mv3 && time_back,
		!open_q && !held_valid_q && !last_time_valid_q)

endmodule

// File: rtl/lwgh_cos_rom.sv
// Cosine lookup of a deck angle with a registered Q1.14 result.
module lwgh_cos_rom (
	input  logic                clk,
	input  logic                en,
	input  logic [15:0]         angle,
	output logic signed [15:0]  cos_q
);

	logic [15:0] mag;
	logic [lwgh_pkg::COS_PROD_W-1:0] scaled;
	logic [lwgh_pkg::COS_IDX_W-1:0] k;
	logic upper;
	logic [lwgh_pkg::COS_QIDX_W-1:0] qidx;
	logic signed [15:0] qval;
	logic signed [15:0] cos_d;

	always_comb begin
		mag = angle[15] ? 16'(-angle) : angle;
		scaled = lwgh_pkg::COS_PROD_W'(mag) * lwgh_pkg::COS_PROD_W'(lwgh_pkg::COS_TABLE_DEPTH)
			+ lwgh_pkg::COS_PROD_W'(16384);
		k = scaled[15 +: lwgh_pkg::COS_IDX_W];
		// second half of the table mirrors the first with the sign flipped
		upper = ((lwgh_pkg::COS_IDX_W + 1)'(k) << 1)
			> (lwgh_pkg::COS_IDX_W + 1)'(lwgh_pkg::COS_TABLE_DEPTH);
		qidx = upper
			? lwgh_pkg::COS_QIDX_W'(lwgh_pkg::COS_IDX_W'(lwgh_pkg::COS_TABLE_DEPTH) - k)
			: lwgh_pkg::COS_QIDX_W'(k);
		qval = lwgh_pkg::COS_QUARTER[qidx];
		cos_d = upper ? -qval : qval;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cos_q <= cos_d;
		end
	end

endmodule
